>>> hdl/c2u_pkg.sv
package c2u_pkg;

    // Sizes
    localparam int C2U_TABLE_ENTRIES = 128;
    localparam int C2U_QUEUE_DEPTH   = 4;

    // Encoding limits and byte marks
    localparam logic [20:0] MAX_ONE    = 21'd127;
    localparam logic [20:0] MAX_TWO    = 21'd2047;
    localparam logic [20:0] MAX_THREE  = 21'd65535;
    localparam logic [20:0] MAX_CODE   = 21'd1114111;
    localparam logic [7:0]  CONT_MASK  = 8'b0011_1111;
    localparam logic [7:0]  CONT_MARK  = 8'b1000_0000;
    localparam logic [7:0]  LEAD_TWO   = 8'b1100_0000;
    localparam logic [7:0]  LEAD_THREE = 8'b1110_0000;
    localparam logic [7:0]  LEAD_FOUR  = 8'b1111_0000;
    localparam logic [7:0]  SPACE_BYTE = 8'd32;
    localparam logic [7:0]  DROP_BYTE  = 8'd255;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_LOAD      = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  in_byte;
        logic [6:0]  table_index;
        logic [20:0] code_point;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // One classified request: 0 to 4 bytes, lead byte in slot 0
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
    } t_run;

    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        return CONT_MARK | {2'b00, bits};
    endfunction

    // UTF-8 encoding of one code point; zero or a value above MAX_CODE gives no bytes
    function automatic t_run encode_utf8(input logic [20:0] cp);
        t_run run;
        run = '0;
        if (cp == '0) begin
            run.count = 3'd0;
        end else if (cp <= MAX_ONE) begin
            run.count    = 3'd1;
            run.bytes[0] = cp[7:0];
        end else if (cp <= MAX_TWO) begin
            run.count    = 3'd2;
            run.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
            run.bytes[1] = cont_byte(cp[5:0]);
        end else if (cp <= MAX_THREE) begin
            run.count    = 3'd3;
            run.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            run.bytes[1] = cont_byte(cp[11:6]);
            run.bytes[2] = cont_byte(cp[5:0]);
        end else if (cp <= MAX_CODE) begin
            run.count    = 3'd4;
            run.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            run.bytes[1] = cont_byte(cp[17:12]);
            run.bytes[2] = cont_byte(cp[11:6]);
            run.bytes[3] = cont_byte(cp[5:0]);
        end
        return run;
    endfunction

endpackage

>>> hdl/codepage_to_utf8_transcoder.sv
// Code-page to UTF-8 transcoder. Push a request when full is low: a load
// request writes one 21-bit code point into the table for bytes 128 to 255
// and produces nothing; a translate request produces 0 to 4 UTF-8 bytes, lead
// byte first, with last set on the final one. Requests are taken one per
// cycle while the run queue has room. The table is read at the accepting
// edge into the lookup stage registers, the byte is classified from them
// combinationally and a non-empty run enters the queue unless it is full;
// the output register then takes the first byte of the run from the queue
// head. The back end sends one byte per cycle while results are popped, so
// the output bytes (up to four per request) are the limit and a request that
// produces nothing still takes its place at the input. The table is usable
// right after reset: per-entry loaded flags make unloaded entries read as
// zero, and no clearing pass is needed.
module codepage_to_utf8_transcoder import c2u_pkg::*; #(
    parameter int TABLE_ENTRIES = C2U_TABLE_ENTRIES,
    parameter int QUEUE_DEPTH   = C2U_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic front_busy;
    t_run q_in_run;
    t_run q_out_run;

    assign full = front_busy;

    // Lookup and classification
    c2u_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (push && !full),
        .i_item   (i_item),
        .i_stall  (q_full),
        .o_busy   (front_busy),
        .o_q_push (q_push),
        .o_q_run  (q_in_run)
    );

    // Run queue between the two halves
    c2u_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_run   (q_in_run),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_run   (q_out_run)
    );

    // Byte serializer
    c2u_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_run   (q_out_run),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_item)
    );

endmodule

>>> hdl/c2u_front.sv
module c2u_front import c2u_pkg::*; #(
    parameter int TABLE_ENTRIES = C2U_TABLE_ENTRIES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic     i_stall,
    output logic     o_busy,
    output logic     o_q_push,
    output t_run     o_q_run
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [20:0]            r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_loaded;
    logic [20:0]            r_rd_data;
    logic                   r_rd_hit;
    logic                   r_s1_valid;
    logic [7:0]             r_s1_byte;
    logic                   load_req;
    logic                   xlat_req;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       rd_idx;
    logic [20:0]            entry_cp;
    t_run                   run;

    assign load_req = i_accept && (i_item.op == OP_LOAD);
    assign xlat_req = i_accept && (i_item.op == OP_TRANSLATE);
    assign wr_idx   = i_item.table_index[IDX_W-1:0];
    assign rd_idx   = i_item.in_byte[IDX_W-1:0];

    // Table store, read registered
    always_ff @(posedge i_clk) begin
        if (load_req) begin
            r_mem[wr_idx] <= i_item.code_point;
        end
        if (xlat_req) begin
            r_rd_data <= r_mem[rd_idx];
            r_s1_byte <= i_item.in_byte;
        end
    end

    // Per-entry loaded flags, so unloaded entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (load_req) begin
                r_loaded[wr_idx] <= 1'b1;
            end
            if (xlat_req) begin
                r_rd_hit <= r_loaded[rd_idx];
            end
        end
    end

    // Lookup stage holds one translate request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_busy) begin
            r_s1_valid <= xlat_req;
        end
    end

    assign entry_cp = r_rd_hit ? r_rd_data : '0;

    // Classify the byte into an output run
    always_comb begin
        run = '0;
        if (r_s1_byte == DROP_BYTE) begin
            run.count = 3'd0;
        end else if (r_s1_byte[7]) begin
            run = encode_utf8(entry_cp);
        end else if (r_s1_byte == 8'd7  || r_s1_byte == 8'd16 || r_s1_byte == 8'd17 ||
                     r_s1_byte == 8'd27 || r_s1_byte == 8'd30 || r_s1_byte == 8'd31) begin
            run.count    = 3'd1;
            run.bytes[0] = SPACE_BYTE;
        end else begin
            run.count    = 3'd1;
            run.bytes[0] = r_s1_byte;
        end
    end

    assign o_busy   = r_s1_valid && i_stall;
    assign o_q_push = r_s1_valid && !i_stall && (run.count != 3'd0);
    assign o_q_run  = run;

endmodule

>>> hdl/c2u_queue.sv
module c2u_queue import c2u_pkg::*; #(
    parameter int DEPTH = C2U_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_run,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_run o_run
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_run             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_run   = r_slots[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_run;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hdl/c2u_back.sv
module c2u_back import c2u_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_run      i_q_run,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);
    logic       r_out_valid;
    t_out_item  r_out;
    logic [1:0] r_idx;
    logic       load_out;
    logic       is_last;

    assign load_out = !r_out_valid || i_pop;
    assign is_last  = ({1'b0, r_idx} == (i_q_run.count - 3'd1));
    assign o_q_pop  = load_out && i_q_valid && is_last;

    // Byte cursor within the head run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load_out && i_q_valid) begin
            r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out && i_q_valid) begin
            r_out.out_byte <= i_q_run.bytes[r_idx];
            r_out.last     <= is_last;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

endmodule

>>> hdl/c2u_checker.sv
module c2u_checker import c2u_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_item
);

    // Reset leaves no result and room for a request
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("outputs not cleared by reset");

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("result changed while stalled");

    // A byte that does not end its run is a multi-byte lead or continuation
    a_nonlast_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_item.last) |-> o_item.out_byte[7])
        else $error("single-byte value without last");

    // The rest of a run follows at once, as continuation bytes
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_item.last) |=>
            (!empty && (o_item.out_byte[7:6] == 2'b10)))
        else $error("run broken or continuation byte malformed");

endmodule

bind codepage_to_utf8_transcoder c2u_checker u_c2u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);
